### rtl/budgeted_lru_residency_table_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the residency table checker
// ----------------------------------------------------------------------------
`ifndef BUDGETED_LRU_RESIDENCY_TABLE_MACROS_SVH
`define BUDGETED_LRU_RESIDENCY_TABLE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define BLRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define BLRT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/blrt_pkg.sv
// ----------------------------------------------------------------------------
// blrt_pkg
// shared constants, codes and types of the budgeted lru residency table
// ----------------------------------------------------------------------------
`default_nettype none

package blrt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PASS_SLOTS    = 8;
  localparam int MAX_EVICT     = 16;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int PW = $clog2(PASS_SLOTS);
  localparam int NW = $clog2(MAX_EVICT + 1);

  localparam logic [11:0] BUDGET_CAP_MEGS = 12'd2048;
  localparam int          MEBI_SHIFT      = 20;

  // opcodes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_BIND   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_FRAME  = 3'd4;
  localparam logic [2:0] OP_EVICT  = 3'd5;
  localparam logic [2:0] OP_FLUSH  = 3'd6;
  localparam logic [2:0] OP_QUERY  = 3'd7;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EVICT    = 3'd3;
  localparam logic [2:0] ST_UNREACH  = 3'd4;

  typedef struct packed {
    logic [63:0] id;
    logic [31:0] bytes;
    logic [31:0] frame;
    logic        atl;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic        atl;
    logic [31:0] bytes;
    logic [63:0] evid;
    logic [39:0] total;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [2:0] status, logic hit, logic atl,
                                  logic [31:0] bytes, logic [63:0] evid,
                                  logic [39:0] total, logic last);
    res_t r;
    r.status = status;
    r.hit    = hit;
    r.atl    = atl;
    r.bytes  = bytes;
    r.evid   = evid;
    r.total  = total;
    r.last   = last;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/blrt_ram.sv
// ----------------------------------------------------------------------------
// blrt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module blrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/budgeted_lru_residency_table.sv
// ----------------------------------------------------------------------------
// budgeted_lru_residency_table
// residency table with byte budget and lru eviction over one entry ram
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// in        in   in_valid/in_ready     opcode, item_id, pass_index, size_bytes,
//                                      is_atlased
// out       out  out_valid/out_ready   status, hit, hit_atlased, hit_bytes,
//                                      evicted_id, total_bytes, last
// cfg       in   cfg_valid/cfg_ready   budget_megs
//
// new frame, flush and an evict within budget or with a zero budget need no walk.
// lookups walk the entry ram once per request.
// over-budget evict: one walk to mark candidates, then one walk per record.
// reset empties the table at once (valid bits); no clearing pass.
// a stalled result holds the block; cfg writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module budgeted_lru_residency_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [63:0] item_id_i,
  input  wire logic [2:0]  pass_index_i,
  input  wire logic [31:0] size_bytes_i,
  input  wire logic        is_atlased_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic             hit_o,
  output logic             hit_atlased_o,
  output logic [31:0]      hit_bytes_o,
  output logic [63:0]      evicted_id_o,
  output logic [39:0]      total_bytes_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [11:0] budget_megs_i
);
  import blrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_EXEC, S_CAND, S_EVLOOP, S_MIN, S_REMOVE, S_OWAIT
  } state_e;

  state_e            state_q, ret_q;
  logic [2:0]        op_q;
  logic [63:0]       id_q;
  logic [2:0]        pass_q;
  logic [31:0]       size_q;
  logic              atl_q;
  logic [TABLE_ENTRIES-1:0] valid_q, cand_q;
  logic [63:0]       slot_q [PASS_SLOTS];
  logic [31:0]       frame_q;
  logic [39:0]       total_q;
  logic              flag_q;
  logic [11:0]       budget_q;
  logic [IW:0]       idx_q;
  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;
  logic              found_q, freef_q, bfound_q;
  logic [IW-1:0]     fidx_q, free_q, bidx_q;
  entry_t            fent_q, bent_q;
  logic [CW-1:0]     cnt_q;
  logic [NW-1:0]     n_q;
  res_t              out_q;
  logic              out_vld_q;

  entry_t            rdata;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  entry_t            ram_wdata;

  // entry storage
  blrt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // derived values
  logic [11:0]   bud_m;
  logic [39:0]   budget_b;
  logic          over;
  logic          rd_last;
  logic          rd_bound;
  logic          pass_ok;
  logic [PW-1:0] slot_idx;
  logic          slot_hit;
  logic [31:0]   room, add_b;
  logic [CW-1:0] wanted;
  logic [63:0]   drop_id;
  logic [39:0]   ins_total;

  assign bud_m    = (budget_q > BUDGET_CAP_MEGS) ? BUDGET_CAP_MEGS : budget_q;
  assign budget_b = 40'(bud_m) << MEBI_SHIFT;
  assign over     = total_q > budget_b;
  assign rd_last  = rd_vld_q && (rd_idx_q == IW'(TABLE_ENTRIES - 1));
  assign pass_ok  = int'(pass_q) < PASS_SLOTS;
  assign slot_idx = PW'(pass_q);
  assign slot_hit = (id_q != 64'd0) && (slot_q[slot_idx] == id_q);
  assign room     = ~fent_q.bytes;
  assign add_b    = (size_q > room) ? room : size_q;
  assign wanted   = (int'(cnt_q) < MAX_EVICT) ? cnt_q : CW'(MAX_EVICT);
  assign drop_id  = (state_q == S_REMOVE) ? bent_q.id : id_q;
  assign ins_total = total_q - (found_q ? 40'(fent_q.bytes) : 40'd0)
                   + (atl_q ? 40'd0 : 40'(size_q));

  // bound check of the entry being read
  always_comb begin
    rd_bound = 1'b0;
    for (int p = 0; p < PASS_SLOTS; p++) begin
      if (rdata.id != 64'd0 && slot_q[p] == rdata.id) rd_bound = 1'b1;
    end
  end

  // entry write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fidx_q;
    ram_wdata = fent_q;
    if (state_q == S_EXEC) begin
      case (op_q)
        OP_INSERT: begin
          ram_we          = found_q || freef_q;
          ram_waddr       = found_q ? fidx_q : free_q;
          ram_wdata.id    = id_q;
          ram_wdata.bytes = atl_q ? 32'd0 : size_q;
          ram_wdata.frame = frame_q;
          ram_wdata.atl   = atl_q;
        end
        OP_ADD: begin
          ram_we          = found_q;
          ram_wdata.bytes = fent_q.bytes + add_b;
        end
        OP_BIND: begin
          ram_we          = pass_ok && !slot_hit && found_q;
          ram_wdata.frame = frame_q;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE) && !out_vld_q;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign hit_o         = out_q.hit;
  assign hit_atlased_o = out_q.atl;
  assign hit_bytes_o   = out_q.bytes;
  assign evicted_id_o  = out_q.evid;
  assign total_bytes_o = out_q.total;
  assign last_o        = out_q.last;

  // control state machine and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      valid_q   <= '0;
      cand_q    <= '0;
      for (int p = 0; p < PASS_SLOTS; p++) slot_q[p] <= '0;
      frame_q   <= 32'd1;
      total_q   <= '0;
      flag_q    <= 1'b0;
      budget_q  <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
      freef_q   <= 1'b0;
      bfound_q  <= 1'b0;
      cnt_q     <= '0;
      n_q       <= '0;
    end else begin
      if (cfg_valid_i) budget_q <= budget_megs_i;

      // ram walk: one read issued per cycle, data in the cycle after
      if (state_q == S_FIND || state_q == S_CAND || state_q == S_MIN) begin
        if (idx_q < (IW+1)'(TABLE_ENTRIES)) begin
          idx_q    <= idx_q + 1'b1;
          rd_vld_q <= 1'b1;
          rd_idx_q <= idx_q[IW-1:0];
        end else begin
          rd_vld_q <= 1'b0;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !out_vld_q) begin
            op_q     <= opcode_i;
            id_q     <= item_id_i;
            pass_q   <= pass_index_i;
            size_q   <= size_bytes_i;
            atl_q    <= is_atlased_i;
            idx_q    <= '0;
            rd_vld_q <= 1'b0;
            ret_q    <= S_IDLE;
            case (opcode_i)
              OP_FRAME: begin
                frame_q   <= frame_q + 32'd1;
                out_q     <= mk_res(ST_OK, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
                out_vld_q <= 1'b1;
                state_q   <= S_OWAIT;
              end
              OP_FLUSH: begin
                valid_q   <= '0;
                for (int p = 0; p < PASS_SLOTS; p++) slot_q[p] <= '0;
                total_q   <= '0;
                out_q     <= mk_res(ST_OK, 1'b0, 1'b0, '0, '0, '0, 1'b1);
                out_vld_q <= 1'b1;
                state_q   <= S_OWAIT;
              end
              OP_EVICT: begin
                if (budget_b == 40'd0 || !over) begin
                  if (budget_b != 40'd0) flag_q <= 1'b0;
                  out_q     <= mk_res(ST_OK, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
                  out_vld_q <= 1'b1;
                  state_q   <= S_OWAIT;
                end else begin
                  cnt_q   <= '0;
                  state_q <= S_CAND;
                end
              end
              default: begin
                found_q <= 1'b0;
                freef_q <= 1'b0;
                state_q <= S_FIND;
              end
            endcase
          end
        end

        // look up the id and the lowest free entry
        S_FIND: begin
          if (rd_vld_q) begin
            if (valid_q[rd_idx_q] && rdata.id == id_q && !found_q) begin
              found_q <= 1'b1;
              fidx_q  <= rd_idx_q;
              fent_q  <= rdata;
            end
            if (!valid_q[rd_idx_q] && !freef_q) begin
              freef_q <= 1'b1;
              free_q  <= rd_idx_q;
            end
          end
          if (rd_last) state_q <= S_EXEC;
        end

        // apply the request
        S_EXEC: begin
          out_vld_q <= 1'b1;
          state_q   <= S_OWAIT;
          case (op_q)
            OP_INSERT: begin
              if (!found_q && !freef_q) begin
                out_q <= mk_res(ST_FULL, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
              end else begin
                valid_q[found_q ? fidx_q : free_q] <= 1'b1;
                if (found_q) begin
                  for (int p = 0; p < PASS_SLOTS; p++) begin
                    if (drop_id != 64'd0 && slot_q[p] == drop_id) slot_q[p] <= '0;
                  end
                end
                total_q <= ins_total;
                out_q   <= mk_res(ST_OK, found_q, 1'b0, '0, '0, ins_total, 1'b1);
              end
            end
            OP_ADD: begin
              if (found_q) begin
                total_q <= total_q + 40'(add_b);
                out_q   <= mk_res(ST_OK, 1'b1, 1'b0, '0, '0,
                                  total_q + 40'(add_b), 1'b1);
              end else begin
                out_q <= mk_res(ST_NOTFOUND, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
              end
            end
            OP_BIND: begin
              if (pass_ok && (slot_hit || found_q)) begin
                if (!slot_hit) slot_q[slot_idx] <= id_q;
                out_q <= mk_res(ST_OK, 1'b1, 1'b0, '0, '0, total_q, 1'b1);
              end else begin
                out_q <= mk_res(ST_NOTFOUND, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
              end
            end
            OP_DELETE: begin
              if (found_q) begin
                valid_q[fidx_q] <= 1'b0;
                for (int p = 0; p < PASS_SLOTS; p++) begin
                  if (drop_id != 64'd0 && slot_q[p] == drop_id) slot_q[p] <= '0;
                end
                total_q <= total_q - 40'(fent_q.bytes);
                out_q   <= mk_res(ST_OK, 1'b1, 1'b0, '0, '0,
                                  total_q - 40'(fent_q.bytes), 1'b1);
              end else begin
                out_q <= mk_res(ST_NOTFOUND, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
              end
            end
            OP_QUERY: begin
              if (found_q) begin
                out_q <= mk_res(ST_OK, 1'b1, fent_q.atl, fent_q.bytes, '0,
                                total_q, 1'b1);
              end else begin
                out_q <= mk_res(ST_NOTFOUND, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
              end
            end
            default: out_q <= mk_res(ST_OK, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
          endcase
        end

        // mark eviction candidates and count them
        S_CAND: begin
          if (rd_vld_q) begin
            cand_q[rd_idx_q] <= valid_q[rd_idx_q] && rdata.frame != frame_q
                                && !rd_bound && !rdata.atl;
            if (valid_q[rd_idx_q] && rdata.frame != frame_q && !rd_bound && !rdata.atl)
              cnt_q <= cnt_q + 1'b1;
          end
          if (rd_last) begin
            n_q     <= '0;
            state_q <= S_EVLOOP;
          end
        end

        // next record or closing result
        S_EVLOOP: begin
          if (CW'(n_q) < wanted && over) begin
            idx_q    <= '0;
            rd_vld_q <= 1'b0;
            bfound_q <= 1'b0;
            state_q  <= S_MIN;
          end else begin
            out_vld_q <= 1'b1;
            state_q   <= S_OWAIT;
            ret_q     <= S_IDLE;
            if (over && CW'(n_q) == cnt_q && !flag_q) begin
              flag_q <= 1'b1;
              out_q  <= mk_res(ST_UNREACH, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
            end else begin
              out_q  <= mk_res(ST_OK, 1'b0, 1'b0, '0, '0, total_q, 1'b1);
            end
          end
        end

        // oldest candidate by frame, then id
        S_MIN: begin
          if (rd_vld_q && cand_q[rd_idx_q] &&
              (!bfound_q || {rdata.frame, rdata.id} < {bent_q.frame, bent_q.id})) begin
            bfound_q <= 1'b1;
            bidx_q   <= rd_idx_q;
            bent_q   <= rdata;
          end
          if (rd_last) state_q <= S_REMOVE;
        end

        // drop it and report
        S_REMOVE: begin
          cand_q[bidx_q]  <= 1'b0;
          valid_q[bidx_q] <= 1'b0;
          for (int p = 0; p < PASS_SLOTS; p++) begin
            if (drop_id != 64'd0 && slot_q[p] == drop_id) slot_q[p] <= '0;
          end
          total_q   <= total_q - 40'(bent_q.bytes);
          n_q       <= n_q + 1'b1;
          out_q     <= mk_res(ST_EVICT, 1'b0, 1'b0, '0, bent_q.id,
                              total_q - 40'(bent_q.bytes), 1'b0);
          out_vld_q <= 1'b1;
          ret_q     <= S_EVLOOP;
          state_q   <= S_OWAIT;
        end

        // hold the result until taken
        S_OWAIT: begin
          if (out_ready_i) begin
            out_vld_q <= 1'b0;
            state_q   <= ret_q;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/blrt_checker.sv
// ----------------------------------------------------------------------------
// blrt_checker
// port-level checks on the residency table results
// ----------------------------------------------------------------------------
`default_nettype none

`include "budgeted_lru_residency_table_macros.svh"

module blrt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic [2:0] status_o,
  input wire logic       hit_o,
  input wire logic       hit_atlased_o,
  input wire logic       last_o
);
  import blrt_pkg::*;

  // no new request is taken while a result is pending
  `BLRT_ASSERT_NEVER(a_ready_pending, in_ready_o && out_valid_o, "request taken with result pending")
  // eviction records are never the closing result
  `BLRT_ASSERT_IMP(a_evict_not_last, out_valid_o && status_o == ST_EVICT, !last_o, "eviction record marked last")
  // unmet budget closes the eviction
  `BLRT_ASSERT_IMP(a_unreach_last, out_valid_o && status_o == ST_UNREACH, last_o, "unmet budget not last")
  // atlased flag only on a hit
  `BLRT_ASSERT_IMP(a_atl_hit, out_valid_o && hit_atlased_o, hit_o, "atlased without hit")

endmodule

bind budgeted_lru_residency_table blrt_checker u_blrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .status_o      (status_o),
  .hit_o         (hit_o),
  .hit_atlased_o (hit_atlased_o),
  .last_o        (last_o)
);

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the budgeted lru residency table. A short scripted
// sequence (some rows with known answers) and a fill past capacity are followed
// by random table traffic over several budgets. Every accepted result is compared
// field by field with an in-bench model of the table. Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blrt_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 2 * (TABLE_ENTRIES + 3);

  // dut interface
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = OP_QUERY;
  logic [63:0] item_id_i = '0;
  logic [2:0]  pass_index_i = '0;
  logic [31:0] size_bytes_i = '0;
  logic        is_atlased_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        hit_o;
  logic        hit_atlased_o;
  logic [31:0] hit_bytes_o;
  logic [63:0] evicted_id_o;
  logic [39:0] total_bytes_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [11:0] budget_megs_i = '0;

  budgeted_lru_residency_table i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .item_id_i,
    .pass_index_i, .size_bytes_i, .is_atlased_i, .out_valid_o, .out_ready_i,
    .status_o, .hit_o, .hit_atlased_o, .hit_bytes_o, .evicted_id_o,
    .total_bytes_o, .last_o, .cfg_valid_i, .cfg_ready_o, .budget_megs_i
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the table
  // ---------------------------------------------------------------------------
  logic        ent_valid [TABLE_ENTRIES];
  logic [63:0] ent_id    [TABLE_ENTRIES];
  logic [31:0] ent_bytes [TABLE_ENTRIES];
  logic [31:0] ent_frame [TABLE_ENTRIES];
  logic        ent_atl   [TABLE_ENTRIES];
  logic [63:0] bound_id  [PASS_SLOTS];
  logic [31:0] frame_no;
  logic [39:0] resident_bytes;
  logic        unmet_flag;
  logic [11:0] budget_megs;

  res_t expected_results[$];
  int   errors = 0;

  function automatic void emit(logic [2:0] st, logic h, logic a, logic [31:0] b,
                               logic [63:0] ev, logic lst);
    res_t r;
    r.status = st;
    r.hit    = h;
    r.atl    = a;
    r.bytes  = b;
    r.evid   = ev;
    r.total  = resident_bytes;
    r.last   = lst;
    expected_results = {expected_results, r};
  endfunction

  function automatic int lookup(logic [63:0] id);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (ent_valid[k] && ent_id[k] == id) return k;
    end
    return -1;
  endfunction

  function automatic bit is_bound(logic [63:0] id);
    if (id == '0) return 1'b0;
    for (int p = 0; p < PASS_SLOTS; p++) begin
      if (bound_id[p] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // remove an entry, its bindings and its bytes
  function automatic void drop_entry(int k);
    if (ent_id[k] != '0) begin
      for (int p = 0; p < PASS_SLOTS; p++) begin
        if (bound_id[p] == ent_id[k]) bound_id[p] = '0;
      end
    end
    resident_bytes = resident_bytes - 40'(ent_bytes[k]);
    ent_valid[k] = 1'b0;
  endfunction

  function automatic void evict_oldest();
    logic [39:0] limit;
    logic [11:0] megs;
    bit          cand [TABLE_ENTRIES];
    int          cnt, want, n, best;
    logic [63:0] vid;
    megs  = (budget_megs > BUDGET_CAP_MEGS) ? BUDGET_CAP_MEGS : budget_megs;
    limit = 40'(megs) << MEBI_SHIFT;
    if (limit == '0) begin
      emit(ST_OK, 0, 0, '0, '0, 1);
      return;
    end
    if (resident_bytes <= limit) begin
      unmet_flag = 1'b0;
      emit(ST_OK, 0, 0, '0, '0, 1);
      return;
    end
    cnt = 0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      cand[k] = ent_valid[k] && ent_frame[k] != frame_no && !is_bound(ent_id[k])
                && !ent_atl[k];
      if (cand[k]) cnt++;
    end
    want = (cnt < MAX_EVICT) ? cnt : MAX_EVICT;
    n = 0;
    // oldest frame first, lowest id breaks ties
    while (n < want && resident_bytes > limit) begin
      best = -1;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (cand[k] && (best < 0 || ent_frame[k] < ent_frame[best] ||
            (ent_frame[k] == ent_frame[best] && ent_id[k] < ent_id[best])))
          best = k;
      end
      if (best < 0) break;
      cand[best] = 0;
      vid = ent_id[best];
      drop_entry(best);
      emit(ST_EVICT, 0, 0, '0, vid, 0);
      n++;
    end
    if (resident_bytes > limit && n == cnt && !unmet_flag) begin
      unmet_flag = 1'b1;
      emit(ST_UNREACH, 0, 0, '0, '0, 1);
    end else begin
      emit(ST_OK, 0, 0, '0, '0, 1);
    end
  endfunction

  // expected results of one accepted request
  function automatic void predict(logic [2:0] op, logic [63:0] id, logic [2:0] pass,
                                  logic [31:0] size, logic atl);
    int          at, k;
    logic [31:0] room;
    at = lookup(id);
    case (op)
      OP_INSERT: begin
        k = at;
        if (at >= 0) begin
          drop_entry(at);
        end else begin
          k = 0;
          while (k < TABLE_ENTRIES && ent_valid[k]) k++;
          if (k == TABLE_ENTRIES) begin
            emit(ST_FULL, 0, 0, '0, '0, 1);
            return;
          end
        end
        ent_valid[k] = 1'b1;
        ent_id[k]    = id;
        ent_atl[k]   = atl;
        ent_bytes[k] = atl ? '0 : size;
        ent_frame[k] = frame_no;
        resident_bytes = resident_bytes + 40'(ent_bytes[k]);
        emit(ST_OK, at >= 0, 0, '0, '0, 1);
      end
      OP_ADD: begin
        if (at < 0) begin
          emit(ST_NOTFOUND, 0, 0, '0, '0, 1);
          return;
        end
        // entry size saturates, the total takes only what was added
        room = 32'hFFFF_FFFF - ent_bytes[at];
        if (size > room) size = room;
        ent_bytes[at] = ent_bytes[at] + size;
        resident_bytes = resident_bytes + 40'(size);
        emit(ST_OK, 1, 0, '0, '0, 1);
      end
      OP_BIND: begin
        if (id != '0 && bound_id[pass] == id) begin
          emit(ST_OK, 1, 0, '0, '0, 1);
        end else if (at < 0) begin
          emit(ST_NOTFOUND, 0, 0, '0, '0, 1);
        end else begin
          bound_id[pass] = id;
          ent_frame[at]  = frame_no;
          emit(ST_OK, 1, 0, '0, '0, 1);
        end
      end
      OP_DELETE: begin
        if (at < 0) begin
          emit(ST_NOTFOUND, 0, 0, '0, '0, 1);
        end else begin
          drop_entry(at);
          emit(ST_OK, 1, 0, '0, '0, 1);
        end
      end
      OP_FRAME: begin
        frame_no = frame_no + 32'd1;
        emit(ST_OK, 0, 0, '0, '0, 1);
      end
      OP_EVICT: evict_oldest();
      OP_FLUSH: begin
        for (int j = 0; j < TABLE_ENTRIES; j++) ent_valid[j] = 1'b0;
        for (int p = 0; p < PASS_SLOTS; p++) bound_id[p] = '0;
        resident_bytes = '0;
        emit(ST_OK, 0, 0, '0, '0, 1);
      end
      default: begin
        if (at < 0) emit(ST_NOTFOUND, 0, 0, '0, '0, 1);
        else emit(ST_OK, 1, ent_atl[at], ent_bytes[at], '0, 1);
      end
    endcase
  endfunction

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) ent_valid[k] = 1'b0;
    for (int p = 0; p < PASS_SLOTS; p++) bound_id[p] = '0;
    frame_no       = 32'd1;
    resident_bytes = '0;
    unmet_flag     = 1'b0;
    budget_megs    = '0;
  end

  // ---------------------------------------------------------------------------
  // result checker, request capture and watchdog
  // ---------------------------------------------------------------------------
  res_t first_of_request;
  bit   at_head = 1'b1;
  int   cycles  = 0;

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want, got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, expected_results.size());
      $display("budgeted_lru_residency_table verification failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_o;
      got.hit    = hit_o;
      got.atl    = hit_atlased_o;
      got.bytes  = hit_bytes_o;
      got.evid   = evicted_id_o;
      got.total  = total_bytes_o;
      got.last   = last_o;
      if (at_head) first_of_request = got;
      at_head = last_o;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, status_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("hit", 64'(want.hit), 64'(got.hit));
        check_field("hit_atlased", 64'(want.atl), 64'(got.atl));
        check_field("hit_bytes", 64'(want.bytes), 64'(got.bytes));
        check_field("evicted_id", want.evid, got.evid);
        check_field("total_bytes", 64'(want.total), 64'(got.total));
        check_field("last", 64'(want.last), 64'(got.last));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o)
      predict(opcode_i, item_id_i, pass_index_i, size_bytes_i, is_atlased_i);
  end

  // ---------------------------------------------------------------------------
  // result receiver with random stalls and an occasional long hold-off
  // ---------------------------------------------------------------------------
  bit rx_stalls = 1'b1;
  bit hold_req  = 1'b0;

  always begin
    int stall;
    @(negedge clk_i);
    if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_req = 1'b0;
    end
    stall = rx_stalls ? $urandom_range(0, 15) : 0;
    if (stall > 0) begin
      out_ready_i <= 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
    @(posedge clk_i);
    while (!out_valid_o) @(posedge clk_i);
  end

  // ---------------------------------------------------------------------------
  // request sender
  // ---------------------------------------------------------------------------
  bit tx_gaps = 1'b1;

  task automatic send_request(logic [2:0] op, logic [63:0] id, logic [2:0] pass,
                              logic [31:0] size, logic atl);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    item_id_i    <= id;
    pass_index_i <= pass;
    size_bytes_i <= size;
    is_atlased_i <= atl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender pauses until every expected result has come
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_budget(logic [11:0] megs);
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    budget_megs_i <= megs;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    budget_megs = megs;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [2:0]  op;
    logic [63:0] id;
    logic [2:0]  pass;
    logic [31:0] size;
    logic        atl;
    bit          known;
    logic [2:0]  st;
    logic        hit;
    logic [39:0] total;
  } script_row_t;

  script_row_t script[$];
  logic [63:0] id_pool[24];

  function automatic void row(logic [2:0] op, logic [63:0] id, logic [2:0] pass,
                              logic [31:0] size, logic atl, bit known = 0,
                              logic [2:0] st = ST_OK, logic hit = 0,
                              logic [39:0] total = '0);
    script_row_t r;
    r = '{op, id, pass, size, atl, known, st, hit, total};
    script = {script, r};
  endfunction

  function automatic logic [31:0] random_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return $urandom();
    return $urandom_range(0, 32'h0030_0000);
  endfunction

  task automatic random_request();
    int          pick;
    logic [2:0]  op;
    logic [63:0] id;
    pick = $urandom_range(0, 99);
    if      (pick < 28) op = OP_INSERT;
    else if (pick < 38) op = OP_ADD;
    else if (pick < 50) op = OP_BIND;
    else if (pick < 58) op = OP_DELETE;
    else if (pick < 70) op = OP_FRAME;
    else if (pick < 85) op = OP_EVICT;
    else if (pick < 87) op = OP_FLUSH;
    else                op = OP_QUERY;
    if ($urandom_range(0, 9) == 0) id = {$urandom(), $urandom()};
    else id = id_pool[$urandom_range(0, 23)];
    send_request(op, id, 3'($urandom_range(0, 7)), random_size(),
                 $urandom_range(0, 7) == 0);
  endtask

  logic [11:0] phase_budget[6] = '{12'd1, 12'd4095, 12'd0, 12'd2048, 12'd3, 12'd16};

  initial begin
    // hold reset, then release it on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < 8; k++) id_pool[k] = 64'(k);
    for (int k = 8; k < 24; k++) id_pool[k] = {$urandom(), $urandom()};

    write_budget(12'd1);

    // scripted sequence, checked against known values where given
    row(OP_QUERY,  64'd5, 0, 0, 0, 1, ST_NOTFOUND, 0, 40'd0);
    row(OP_EVICT,  '0,    0, 0, 0, 1, ST_OK,       0, 40'd0);
    row(OP_INSERT, '1,    0, 32'hFFFF_FFF0, 0, 1, ST_OK, 0, 40'hFFFF_FFF0);
    row(OP_ADD,    '1,    0, 32'hFFFF_FFFF, 0, 1, ST_OK, 1, 40'hFFFF_FFFF);
    row(OP_QUERY,  '1,    0, 0, 0);
    row(OP_INSERT, '0,    0, 32'h0010_0000, 1, 1, ST_OK, 0, 40'hFFFF_FFFF);
    row(OP_BIND,   '0,    7, 0, 0, 1, ST_OK, 1, 40'hFFFF_FFFF);
    row(OP_BIND,   64'd3, 0, 0, 0, 1, ST_NOTFOUND, 0, 40'hFFFF_FFFF);
    row(OP_INSERT, 64'd3, 0, 32'd1000, 0);
    row(OP_BIND,   64'd3, 0, 0, 0);
    row(OP_BIND,   64'd3, 0, 0, 0);
    row(OP_INSERT, 64'd3, 0, 32'h0020_0000, 0);
    row(OP_EVICT,  '0,    0, 0, 0);
    row(OP_EVICT,  '0,    0, 0, 0);
    row(OP_FRAME,  '0,    0, 0, 0);
    row(OP_INSERT, 64'd9, 0, 32'h0008_0000, 0);
    row(OP_EVICT,  '0,    0, 0, 0);
    row(OP_DELETE, 64'd99, 0, 0, 0, 1, ST_NOTFOUND, 0, 40'h0008_0000);
    row(OP_DELETE, '0,    0, 0, 0);
    row(OP_ADD,    64'd42, 0, 32'd7, 0);
    row(OP_INSERT, 64'd7, 0, 32'd5, 1);
    row(OP_QUERY,  64'd7, 0, 0, 0);
    row(OP_FLUSH,  '0,    0, 0, 0, 1, ST_OK, 0, 40'd0);
    row(OP_QUERY,  64'd7, 0, 0, 0, 1, ST_NOTFOUND, 0, 40'd0);
    row(OP_FRAME,  '0,    0, 0, 0);
    foreach (script[i]) begin
      send_request(script[i].op, script[i].id, script[i].pass, script[i].size,
                   script[i].atl);
      drain();
      if (script[i].known && (first_of_request.status !== script[i].st ||
          first_of_request.hit !== script[i].hit ||
          first_of_request.total !== script[i].total)) begin
        $display("%0t: row %0d expected status %0d hit %0d total %0h got %0d %0d %0h",
                 $time, i, script[i].st, script[i].hit, script[i].total,
                 first_of_request.status, first_of_request.hit, first_of_request.total);
        errors++;
      end
    end

    // fill past capacity, then age and trim
    tx_gaps = 1'b0;
    for (int k = 0; k < 70; k++)
      send_request(OP_INSERT, 64'(1000 + k), 0, $urandom_range(0, 32'h0004_0000), 0);
    send_request(OP_FRAME, '0, 0, 0, 0);
    for (int k = 0; k < 6; k++) send_request(OP_EVICT, '0, 0, 0, 0);
    tx_gaps = 1'b1;
    drain();

    // random traffic over several budgets
    foreach (phase_budget[ph]) begin
      write_budget(phase_budget[ph]);
      tx_gaps   = (ph != 1);
      rx_stalls = (ph != 3);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < 40; k++) random_request();
      drain();
    end
    rx_stalls = 1'b1;

    // wait out the tail
    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("budgeted_lru_residency_table verification clean");
    end else begin
      $display("budgeted_lru_residency_table verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
